[hdl/sse_pkg.sv]
// Shared types and constants for the sample statistics engine.
// Depends on nothing; every other file of the block imports it.
package sse_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = 10;
  localparam int CNT_W       = 11;
  localparam int SUM_W       = 42;
  localparam int ACC_W       = 75;
  localparam int VAR_W       = 63;

  localparam logic [VAR_W-1:0] VAR_SAT = {VAR_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_P1,
    S_MDIV,
    S_P2,
    S_VDIV,
    S_SD,
    S_SDMDIV,
    S_SDMSQ,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hdl/sse_store.sv]
// Sample memory: one write port and one registered read port.
// Depends on sse_pkg for the request structure and depth.
module sse_store
  import sse_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);

  logic [31:0] mem [MAX_SAMPLES];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/sse_div.sv]
// Restoring divider, one quotient bit per cycle, for mean and variances.
// Depends on sse_pkg for widths and the status structure.
module sse_div
  import sse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [ACC_W-1:0] quotient,
  output unit_stat_t       stat
);

  localparam int STEP_W = $clog2(ACC_W);

  logic [ACC_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  d_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial   = {rem_r, q_r[ACC_W-1]};
    diff    = trial - {1'b0, d_r};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    q_nxt   = {q_r[ACC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= STEP_W'(ACC_W - 1);
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/sse_sqrt.sv]
// Integer square root, one result bit per cycle.
// Depends on sse_pkg for widths and the status structure.
module sse_sqrt
  import sse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAR_W-1:0] radicand,
  output logic [31:0]      root,
  output unit_stat_t       stat
);

  logic [63:0] v_r, res_r, bit_r, trial;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {1'b0, radicand};
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
      cnt_r <= 5'd31;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign root      = res_r[31:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/sample_statistics_engine_top.sv]
// Top level of the sample statistics engine: sequencer, datapath and ports.
// Depends on sse_pkg, sse_store, sse_div and sse_sqrt.
//
// Channel | Direction | Contents
// in_     | request   | tuser: opcode[1:0]; tdata: sample[31:0], element_index[41:32]
// out_    | result    | tuser: status[1:0]; tdata: count, mean, variance, std_dev,
//         |           |   std_of_mean, minimum, maximum, element_value
// cfg_    | write     | data: bessel_correction
//
// An add, a clear or a read of an index out of range completes in the cycle
// it is accepted, so these run at one request per cycle. A read in range
// waits for the registered memory read port. A report makes two passes over
// the memory read port, three through the bit-serial divider and two
// through the bit-serial root unit, or stops after the second memory pass if
// the variance divisor is zero. No request is taken while a report or a
// read is in progress, nor while the result register is full and stalled.
// Reset is synchronous and active low; it empties the store logically.
module sample_statistics_engine_top
  import sse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  input  logic [47:0]  in_tdata,   // sample[31:0], element_index[41:32], zeros
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status[1:0]
  // sample_count[10:0], mean[42:11], variance[105:43], std_dev[137:106],
  // std_of_mean[169:138], minimum[201:170], maximum[233:202],
  // element_value[265:234], zeros
  output logic [271:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data    // bessel_correction
);

  // Request fields.
  opcode_t           op;
  logic [31:0]       sample;
  logic [ADDR_W-1:0] idx;

  assign op     = opcode_t'(in_tuser);
  assign sample = in_tdata[31:0];
  assign idx    = in_tdata[41:32];

  state_t state_r, state_nxt;

  logic             bessel_r;
  logic [CNT_W-1:0] count_r;

  // Result register.
  logic             out_valid_r;
  logic [1:0]       o_status_r;
  logic [CNT_W-1:0] o_count_r;
  logic [31:0]      o_mean_r, o_sd_r, o_sdm_r, o_min_r, o_max_r, o_elem_r;
  logic [VAR_W-1:0] o_var_r;

  // Working registers for a report or a read.
  logic [CNT_W-1:0] n_r, ptr_r;
  logic             v1_r, v2_r, v3_r, first_r;
  logic [SUM_W-1:0] sum_r;
  logic [31:0]      min_r, max_r, mean_r, dabs_r, sd_r, sdm_r, elem_r;
  logic [63:0]      sq_r;
  logic [ACC_W-1:0] acc_r;
  logic [VAR_W-1:0] var_r;

  // Sequencer outputs.
  logic             slot_free, in_fire, idx_ok, direct_load, fin_load;
  logic             p1_done, p2_done, pass_re;
  logic             div_start, sq_start;
  logic [ACC_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor, var_div;
  logic [VAR_W-1:0] sq_radicand, var_sat;
  mem_req_t         mem_req;
  logic [31:0]      rdata;
  logic [ACC_W-1:0] quotient;
  logic [31:0]      root;
  unit_stat_t       div_stat, sq_stat;

  logic [SUM_W-1:0] sum_mag;
  logic [32:0]      diff;
  logic [31:0]      q_mean;

  assign slot_free = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign idx_ok    = ({1'b0, idx} < count_r);
  assign var_div   = bessel_r ? (n_r - 1'b1) : n_r;
  assign p1_done   = (state_r == S_P1) && (ptr_r == n_r) && !v1_r;
  assign p2_done   = (state_r == S_P2) && (ptr_r == n_r) && !v1_r && !v2_r && !v3_r;
  assign pass_re   = ((state_r == S_P1) || (state_r == S_P2)) && (ptr_r < n_r);
  assign cfg_ready = 1'b1;

  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign q_mean  = quotient[31:0];
  assign var_sat = (quotient[ACC_W-1:VAR_W] != '0) ? VAR_SAT : quotient[VAR_W-1:0];
  assign diff    = {rdata[31], rdata} - {mean_r[31], mean_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && op == OP_READ && idx_ok) begin
          state_nxt = S_RD;
        end else if (in_fire && op == OP_REPORT && count_r != '0) begin
          state_nxt = S_P1;
        end
      end
      S_RD:     state_nxt = S_FIN;
      S_P1:     if (p1_done) state_nxt = S_MDIV;
      S_MDIV:   if (div_stat.done) state_nxt = S_P2;
      S_P2: begin
        if (p2_done) begin
          state_nxt = (var_div == '0) ? S_FIN : S_VDIV;
        end
      end
      S_VDIV:   if (div_stat.done) state_nxt = S_SD;
      S_SD:     if (sq_stat.done) state_nxt = S_SDMDIV;
      S_SDMDIV: if (div_stat.done) state_nxt = S_SDMSQ;
      S_SDMSQ:  if (sq_stat.done) state_nxt = S_FIN;
      S_FIN:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready     = (state_r == S_IDLE) && slot_free;
    mem_req.we    = in_fire && op == OP_ADD && (count_r < CNT_W'(MAX_SAMPLES));
    mem_req.waddr = count_r[ADDR_W-1:0];
    mem_req.wdata = sample;
    mem_req.re    = (in_fire && op == OP_READ && idx_ok) || pass_re;
    mem_req.raddr = (state_r == S_IDLE) ? idx : ptr_r[ADDR_W-1:0];
    direct_load   = in_fire && !(op == OP_READ && idx_ok)
                    && !(op == OP_REPORT && count_r != '0);
    fin_load      = (state_r == S_FIN) && slot_free;
    div_start     = 1'b0;
    div_dividend  = acc_r;
    div_divisor   = n_r;
    sq_start      = 1'b0;
    sq_radicand   = var_sat;
    case (state_r)
      S_P1: begin
        div_start    = p1_done;
        div_dividend = {{(ACC_W-SUM_W){1'b0}}, sum_mag} + ACC_W'(n_r >> 1);
      end
      S_P2: begin
        div_start   = p2_done && (var_div != '0);
        div_divisor = var_div;
      end
      S_VDIV: sq_start = div_stat.done;
      S_SD: begin
        div_start    = sq_stat.done;
        div_dividend = {{(ACC_W-VAR_W){1'b0}}, var_r};
      end
      S_SDMDIV: begin
        sq_start    = div_stat.done;
        sq_radicand = quotient[VAR_W-1:0];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      bessel_r    <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        bessel_r <= cfg_data[0];
      end
      if (mem_req.we) begin
        count_r <= count_r + 1'b1;
      end else if (in_fire && op == OP_CLEAR) begin
        count_r <= '0;
      end
      if (direct_load || fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      v1_r <= pass_re;
      v2_r <= v1_r && (state_r == S_P2);
      v3_r <= v2_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      n_r     <= count_r;
      ptr_r   <= '0;
      first_r <= 1'b1;
      sum_r   <= '0;
      acc_r   <= '0;
      mean_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      var_r   <= '0;
      sd_r    <= '0;
      sdm_r   <= '0;
      elem_r  <= '0;
    end
    if (state_r == S_RD) begin
      elem_r <= rdata;
    end
    if (pass_re) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (p1_done) begin
      ptr_r <= '0;
    end
    // First pass: sum, minimum and maximum.
    if (state_r == S_P1 && v1_r) begin
      sum_r   <= sum_r + {{(SUM_W-32){rdata[31]}}, rdata};
      first_r <= 1'b0;
      if (first_r || $signed(rdata) < $signed(min_r)) begin
        min_r <= rdata;
      end
      if (first_r || $signed(rdata) > $signed(max_r)) begin
        max_r <= rdata;
      end
    end
    if (state_r == S_MDIV && div_stat.done) begin
      mean_r <= sum_r[SUM_W-1] ? (~q_mean + 1'b1) : q_mean;
    end
    // Second pass: squared deviations from the rounded mean.
    dabs_r <= diff[32] ? (~diff[31:0] + 1'b1) : diff[31:0];
    sq_r   <= dabs_r * dabs_r;
    if (state_r == S_P2 && v3_r) begin
      acc_r <= acc_r + {{(ACC_W-64){1'b0}}, sq_r};
    end
    if (state_r == S_VDIV && div_stat.done) begin
      var_r <= var_sat;
    end
    if (state_r == S_SD && sq_stat.done) begin
      sd_r <= root;
    end
    if (state_r == S_SDMSQ && sq_stat.done) begin
      sdm_r <= root;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (direct_load) begin
      o_mean_r <= '0;
      o_var_r  <= '0;
      o_sd_r   <= '0;
      o_sdm_r  <= '0;
      o_min_r  <= '0;
      o_max_r  <= '0;
      o_elem_r <= '0;
      case (op)
        OP_ADD: begin
          if (mem_req.we) begin
            o_status_r <= STAT_OK;
            o_count_r  <= count_r + 1'b1;
          end else begin
            o_status_r <= STAT_FULL;
            o_count_r  <= count_r;
          end
        end
        OP_CLEAR: begin
          o_status_r <= STAT_OK;
          o_count_r  <= '0;
        end
        OP_READ: begin
          o_status_r <= STAT_RANGE;
          o_count_r  <= count_r;
        end
        default: begin
          o_status_r <= STAT_OK;
          o_count_r  <= count_r;
        end
      endcase
    end else if (fin_load) begin
      o_status_r <= STAT_OK;
      o_count_r  <= count_r;
      o_mean_r   <= mean_r;
      o_var_r    <= var_r;
      o_sd_r     <= sd_r;
      o_sdm_r    <= sdm_r;
      o_min_r    <= min_r;
      o_max_r    <= max_r;
      o_elem_r   <= elem_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {6'b0, o_elem_r, o_max_r, o_min_r, o_sdm_r, o_sd_r,
                       o_var_r, o_mean_r, o_count_r};

  sse_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  sse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  sse_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_radicand),
    .root     (root),
    .stat     (sq_stat)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SAMPLES))
    else $error("stored count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_ADD && count_r == CNT_W'(MAX_SAMPLES))
    |=> (out_tvalid && out_tuser == STAT_FULL && $stable(count_r)))
    else $error("add to a full store not dropped");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_stat.busy && sq_stat.busy))
    else $error("divider and root unit busy together");

  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE && !div_stat.busy && !sq_stat.busy))
    else $error("request accepted while a report is in progress");
`endif

endmodule
